// ===== rtl/sbsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbsr_pkg;

  localparam int BITS_PER_READ = 8;
  localparam int COUNT_WIDTH   = 16;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_READ + 1);
  localparam int BYTE_W        = 8;
  localparam int REG_IDX_W     = 3;
  localparam int REG_DATA_W    = 16;
  localparam int CHAIN_STEPS   = 7;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] DRIVE_RELEASE = 2'd0;
  localparam logic [1:0] DRIVE_LOW     = 2'd1;
  localparam logic [1:0] DRIVE_HIGH    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_START_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RESP_CHECK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIT_SAMPLE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_TIMEOUT = 3'd5;

  localparam logic [15:0] RST_START_LOW    = 16'd20000;
  localparam logic [7:0]  RST_DRIVE_HIGH   = 8'd30;
  localparam logic [7:0]  RST_SETTLE       = 8'd40;
  localparam logic [7:0]  RST_RESP_CHECK   = 8'd80;
  localparam logic [7:0]  RST_BIT_SAMPLE   = 8'd40;
  localparam logic [15:0] RST_EDGE_TIMEOUT = 16'd2000;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_LOW,
    PH_DRIVE_HIGH,
    PH_SETTLE,
    PH_CHECK_HIGH,
    PH_WAIT_FALL,
    PH_RD_RISE,
    PH_RD_SAMPLE,
    PH_RD_FALL
  } phase_t;

  typedef struct packed {
    logic [15:0] start_low_us;
    logic [7:0]  drive_high_us;
    logic [7:0]  settle_us;
    logic [7:0]  response_check_us;
    logic [7:0]  bit_sample_us;
    logic [15:0] edge_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        drive_mode;
    logic              busy_res;
    logic              start_done;
    logic              response_ok;
    logic              byte_done;
    logic [BYTE_W-1:0] byte_value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/sbsr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       line_level;

  modport source (output valid, output kind, output line_level, input ready);
  modport sink (input valid, input kind, input line_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbsr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive_mode;
  logic       busy_res;
  logic       start_done;
  logic       response_ok;
  logic       byte_done;
  logic [7:0] byte_value;

  modport source (
    output valid, output drive_mode, output busy_res, output start_done,
    output response_ok, output byte_done, output byte_value, input ready
  );
  modport sink (
    input valid, input drive_mode, input busy_res, input start_done,
    input response_ok, input byte_done, input byte_value, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/sbsr_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbsr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_en,
  input  logic [sbsr_pkg::REG_IDX_W-1:0]  reg_index,
  input  logic [sbsr_pkg::REG_DATA_W-1:0] write_data,
  output sbsr_pkg::cfg_t                   cfg
);
  import sbsr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_us      <= RST_START_LOW;
      cfg.drive_high_us     <= RST_DRIVE_HIGH;
      cfg.settle_us         <= RST_SETTLE;
      cfg.response_check_us <= RST_RESP_CHECK;
      cfg.bit_sample_us     <= RST_BIT_SAMPLE;
      cfg.edge_timeout_us   <= RST_EDGE_TIMEOUT;
    end else if (write_en) begin
      unique case (reg_index)
        REG_START_LOW:    cfg.start_low_us      <= write_data;
        REG_DRIVE_HIGH:   cfg.drive_high_us     <= write_data[7:0];
        REG_SETTLE:       cfg.settle_us         <= write_data[7:0];
        REG_RESP_CHECK:   cfg.response_check_us <= write_data[7:0];
        REG_BIT_SAMPLE:   cfg.bit_sample_us     <= write_data[7:0];
        REG_EDGE_TIMEOUT: cfg.edge_timeout_us   <= write_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbsr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbsr_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [1:0]        kind,
  input  logic              line_level,
  input  sbsr_pkg::cfg_t    cfg,
  output sbsr_pkg::result_t result
);
  import sbsr_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > REG_DATA_W) ? COUNT_WIDTH : REG_DATA_W;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] wait_count, wait_count_next;
  logic [BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic [BYTE_W-1:0]      shift_byte, shift_byte_next;
  logic                   response_flag, response_flag_next;
  logic                   start_done, byte_done, stay, full;
  logic [BIT_IDX_W-1:0]   fill_count;

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] count,
                                   input logic [REG_DATA_W-1:0] limit);
    return CMP_W'(count) >= CMP_W'(limit);
  endfunction

  // zero sample delay and zero timeout finish every remaining bit at once
  assign full = (cfg.edge_timeout_us == '0) && (cfg.bit_sample_us == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      response_flag <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      wait_count    <= wait_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      response_flag <= response_flag_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    wait_count_next    = wait_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    response_flag_next = response_flag;
    start_done         = 1'b0;
    byte_done          = 1'b0;
    stay               = 1'b0;
    fill_count         = '0;

    if (phase == PH_IDLE) begin
      if (kind == KIND_START) begin
        response_flag_next = 1'b0;
        phase_next         = PH_START_LOW;
        wait_count_next    = '0;
      end else if (kind == KIND_READ) begin
        bit_index_next  = '0;
        shift_byte_next = '0;
        phase_next      = PH_RD_RISE;
        wait_count_next = '0;
      end
    end

    for (int k = 0; k < CHAIN_STEPS; k++) begin
      if (!stay && phase_next != PH_IDLE) begin
        unique case (phase_next)
          PH_START_LOW: begin
            if (reached(wait_count_next, cfg.start_low_us)) begin
              phase_next      = PH_DRIVE_HIGH;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_DRIVE_HIGH: begin
            if (reached(wait_count_next, REG_DATA_W'(cfg.drive_high_us))) begin
              phase_next      = PH_SETTLE;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_SETTLE: begin
            if (reached(wait_count_next, REG_DATA_W'(cfg.settle_us))) begin
              phase_next      = line_level ? PH_WAIT_FALL : PH_CHECK_HIGH;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_CHECK_HIGH: begin
            if (reached(wait_count_next, REG_DATA_W'(cfg.response_check_us))) begin
              if (line_level) begin
                response_flag_next = 1'b1;
              end
              phase_next      = PH_WAIT_FALL;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_WAIT_FALL: begin
            if (!line_level || reached(wait_count_next, cfg.edge_timeout_us)) begin
              start_done      = 1'b1;
              phase_next      = PH_IDLE;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_RD_RISE: begin
            if (full && wait_count_next == '0) begin
              fill_count      = BIT_IDX_W'(BITS_PER_READ) - bit_index_next;
              shift_byte_next = line_level ? ~((~shift_byte_next) << fill_count)
                                           : (shift_byte_next << fill_count);
              bit_index_next  = BIT_IDX_W'(BITS_PER_READ);
              byte_done       = 1'b1;
              phase_next      = PH_IDLE;
              wait_count_next = '0;
            end else if (line_level || reached(wait_count_next, cfg.edge_timeout_us)) begin
              phase_next      = PH_RD_SAMPLE;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_RD_SAMPLE: begin
            if (reached(wait_count_next, REG_DATA_W'(cfg.bit_sample_us))) begin
              shift_byte_next = {shift_byte_next[BYTE_W-2:0], line_level};
              bit_index_next  = bit_index_next + BIT_IDX_W'(1);
              phase_next      = PH_RD_FALL;
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          PH_RD_FALL: begin
            if (!line_level || reached(wait_count_next, cfg.edge_timeout_us)) begin
              if (bit_index_next >= BIT_IDX_W'(BITS_PER_READ)) begin
                byte_done  = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_RD_RISE;
              end
              wait_count_next = '0;
            end else begin
              stay = 1'b1;
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
            stay            = 1'b1;
          end
        endcase
      end
    end

    if (stay && wait_count_next != '1) begin
      wait_count_next = wait_count_next + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    case (phase_next)
      PH_START_LOW:  result.drive_mode = DRIVE_LOW;
      PH_DRIVE_HIGH: result.drive_mode = DRIVE_HIGH;
      default:       result.drive_mode = DRIVE_RELEASE;
    endcase
    result.busy_res    = (phase_next != PH_IDLE);
    result.start_done  = start_done;
    result.response_ok = response_flag_next;
    result.byte_done   = byte_done;
    result.byte_value  = shift_byte_next;
  end

endmodule

`default_nettype wire

// ===== rtl/single_bus_sensor_byte_reader_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake     payload
// in_ch     in   valid/ready   kind, line_level
// out_ch    out  valid/ready   drive_mode, busy_res, start_done, response_ok,
//                              byte_done, byte_value
// config    in   write_en      reg_index, write_data
//
// one transaction in, one transaction out; a new tick is taken every cycle unless the result is stalled
// a tick passes the input register, then the result register
// the sequencer chain for one tick settles between those two registers
// reset is synchronous; no clearing pass, the block is ready right after reset
// a stalled result holds the sequencer; the input register keeps one tick

module single_bus_sensor_byte_reader_unit (
  input  logic                             clk,
  input  logic                             rst,
  sbsr_in_if.sink                          in_ch,
  sbsr_out_if.source                       out_ch,
  input  logic                             write_en,
  input  logic [sbsr_pkg::REG_IDX_W-1:0]  reg_index,
  input  logic [sbsr_pkg::REG_DATA_W-1:0] write_data
);
  import sbsr_pkg::*;

  cfg_t       cfg;
  result_t    result, res_q;
  logic       in_valid_q, res_valid, res_free, advance;
  logic [1:0] kind_q;
  logic       line_q;

  assign res_free    = !res_valid || out_ch.ready;
  assign advance     = in_valid_q && res_free;
  assign in_ch.ready = !in_valid_q || res_free;

  sbsr_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .cfg        (cfg)
  );

  sbsr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .kind       (kind_q),
    .line_level (line_q),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_q <= in_ch.kind;
      line_q <= in_ch.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.drive_mode  = res_q.drive_mode;
  assign out_ch.busy_res    = res_q.busy_res;
  assign out_ch.start_done  = res_q.start_done;
  assign out_ch.response_ok = res_q.response_ok;
  assign out_ch.byte_done   = res_q.byte_done;
  assign out_ch.byte_value  = res_q.byte_value;

endmodule

`default_nettype wire

// ===== tb/tb_single_bus_sensor_byte_reader_unit.sv =====
`timescale 1ns / 1ps

module tb_single_bus_sensor_byte_reader_unit;
  import sbsr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PHASES = 11;
  localparam int ITEMS_PER_HALF = 60;
  localparam int NUM_DIRECTED = 23;
  localparam int TAIL_TICKS = 24;
  localparam result_t ZERO_RESULT = '0;

  typedef struct packed {
    logic [1:0] kind;
    logic       line;
    logic       has_want;
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic write_en;
  logic [REG_IDX_W-1:0] reg_index;
  logic [REG_DATA_W-1:0] write_data;

  sbsr_in_if in_ch ();
  sbsr_out_if out_ch ();

  single_bus_sensor_byte_reader_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .write_en(write_en),
    .reg_index(reg_index),
    .write_data(write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted sequencer state and registers
  phase_t seq_phase;
  logic [COUNT_WIDTH-1:0] dwell;
  int bits_got;
  logic [BYTE_W-1:0] shift_reg;
  logic answered;
  cfg_t active_cfg;

  // sensor emulation
  logic garble;
  logic data_bit;

  result_t expected_results[$];
  result_t head;
  int n_sent = 0;
  int n_taken = 0;
  int n_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int tx_max = 17;
  int rx_max = 17;
  int holds_asked = 0;
  int holds_done = 0;

  stim_row_t dir_rows [NUM_DIRECTED] = '{
    '{KIND_TICK, 1'b0, 1'b1, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b1, ZERO_RESULT},
    '{KIND_UNUSED, 1'b1, 1'b1, ZERO_RESULT},
    '{KIND_START, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_START, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_READ, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_READ, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b1, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_UNUSED, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT},
    '{KIND_TICK, 1'b0, 1'b0, ZERO_RESULT}
  };

  function automatic void goto_phase(input phase_t nxt);
    seq_phase = nxt;
    dwell = '0;
  endfunction

  function automatic result_t next_reader_result(input logic [1:0] k, input logic ln);
    result_t r;
    logic hold;
    int steps;
    r = '0;
    hold = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (k == KIND_START) begin
        answered = 1'b0;
        goto_phase(PH_START_LOW);
      end else if (k == KIND_READ) begin
        bits_got = 0;
        shift_reg = '0;
        goto_phase(PH_RD_RISE);
      end
    end
    for (steps = 0; steps < 4 * BITS_PER_READ + 16 && !hold; steps++) begin
      case (seq_phase)
        PH_START_LOW: begin
          if (dwell >= active_cfg.start_low_us) goto_phase(PH_DRIVE_HIGH);
          else hold = 1'b1;
        end
        PH_DRIVE_HIGH: begin
          if (dwell >= active_cfg.drive_high_us) goto_phase(PH_SETTLE);
          else hold = 1'b1;
        end
        PH_SETTLE: begin
          if (dwell >= active_cfg.settle_us) goto_phase(ln ? PH_WAIT_FALL : PH_CHECK_HIGH);
          else hold = 1'b1;
        end
        PH_CHECK_HIGH: begin
          if (dwell >= active_cfg.response_check_us) begin
            if (ln) answered = 1'b1;
            goto_phase(PH_WAIT_FALL);
          end else hold = 1'b1;
        end
        PH_WAIT_FALL: begin
          if (!ln || dwell >= active_cfg.edge_timeout_us) begin
            r.start_done = 1'b1;
            goto_phase(PH_IDLE);
          end else hold = 1'b1;
        end
        PH_RD_RISE: begin
          if (ln || dwell >= active_cfg.edge_timeout_us) goto_phase(PH_RD_SAMPLE);
          else hold = 1'b1;
        end
        PH_RD_SAMPLE: begin
          if (dwell >= active_cfg.bit_sample_us) begin
            shift_reg = {shift_reg[BYTE_W-2:0], ln};
            bits_got++;
            goto_phase(PH_RD_FALL);
          end else hold = 1'b1;
        end
        PH_RD_FALL: begin
          if (!ln || dwell >= active_cfg.edge_timeout_us) begin
            if (bits_got >= BITS_PER_READ) begin
              r.byte_done = 1'b1;
              goto_phase(PH_IDLE);
            end else goto_phase(PH_RD_RISE);
          end else hold = 1'b1;
        end
        default: begin
          seq_phase = PH_IDLE;
          dwell = '0;
          hold = 1'b1;
        end
      endcase
      if (seq_phase == PH_IDLE) break;
    end
    // counter saturates
    if (hold && dwell != '1) dwell++;
    if (seq_phase == PH_START_LOW) r.drive_mode = DRIVE_LOW;
    else if (seq_phase == PH_DRIVE_HIGH) r.drive_mode = DRIVE_HIGH;
    else r.drive_mode = DRIVE_RELEASE;
    r.busy_res = (seq_phase != PH_IDLE);
    r.response_ok = answered;
    r.byte_value = shift_reg;
    return r;
  endfunction

  // line level a well-behaved sensor would give, with some noise
  function automatic logic pick_line();
    if (garble || $urandom_range(0, 15) == 0) return 1'($urandom_range(0, 1));
    case (seq_phase)
      PH_START_LOW: return 1'b0;
      PH_SETTLE: return (dwell >= active_cfg.settle_us) ? 1'b0 : 1'b1;
      PH_WAIT_FALL: return ($urandom_range(0, 3) != 0);
      PH_RD_RISE: begin
        data_bit = 1'($urandom_range(0, 1));
        return ($urandom_range(0, 2) == 0);
      end
      PH_RD_SAMPLE: return data_bit;
      PH_RD_FALL: return ($urandom_range(0, 2) != 0);
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    if (seq_phase == PH_IDLE) begin
      r = $urandom_range(0, 19);
      garble = ($urandom_range(0, 4) == 0);
      if (r < 9) return KIND_START;
      if (r < 18) return KIND_READ;
      if (r == 18) return KIND_TICK;
      return KIND_UNUSED;
    end
    r = $urandom_range(0, 15);
    if (r == 0) return KIND_START;
    if (r == 1) return KIND_READ;
    if (r == 2) return KIND_UNUSED;
    return KIND_TICK;
  endfunction

  function automatic cfg_t random_small_cfg();
    cfg_t c;
    c.start_low_us = 16'($urandom_range(1, 12));
    c.drive_high_us = 8'($urandom_range(0, 6));
    c.settle_us = 8'($urandom_range(0, 6));
    c.response_check_us = 8'($urandom_range(0, 6));
    c.bit_sample_us = 8'($urandom_range(0, 6));
    c.edge_timeout_us = 16'($urandom_range(0, 10));
    return c;
  endfunction

  task automatic send_tick(input logic [1:0] k, input logic ln, input logic has_want,
                           input result_t want);
    int gap;
    result_t got;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.line_level <= ln;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = next_reader_result(k, ln);
    expected_results.push_back(has_want ? want : got);
    n_sent++;
  endtask

  task automatic run_to_idle();
    while (seq_phase != PH_IDLE) send_tick(KIND_TICK, pick_line(), 1'b0, ZERO_RESULT);
  endtask

  task automatic run_random(input int count);
    int n;
    logic [1:0] k;
    for (n = 0; n < count; n++) begin
      k = pick_kind();
      send_tick(k, pick_line(), 1'b0, ZERO_RESULT);
    end
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
    write_en <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_t c);
    put_reg(REG_START_LOW, c.start_low_us);
    put_reg(REG_DRIVE_HIGH, {8'd0, c.drive_high_us});
    put_reg(REG_SETTLE, {8'd0, c.settle_us});
    put_reg(REG_RESP_CHECK, {8'd0, c.response_check_us});
    put_reg(REG_BIT_SAMPLE, {8'd0, c.bit_sample_us});
    put_reg(REG_EDGE_TIMEOUT, c.edge_timeout_us);
    write_en <= 1'b0;
    active_cfg = c;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (n_checked >= n_taken) begin
          $error("result transaction with nothing pending");
          fail_count++;
        end else begin
          head = expected_results.pop_front();
          check_field("drive_mode", head.drive_mode, out_ch.drive_mode);
          check_field("busy_res", head.busy_res, out_ch.busy_res);
          check_field("start_done", head.start_done, out_ch.start_done);
          check_field("response_ok", head.response_ok, out_ch.response_ok);
          check_field("byte_done", head.byte_done, out_ch.byte_done);
          check_field("byte_value", head.byte_value, out_ch.byte_value);
          n_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) n_taken++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_asked != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int i;
    int p;
    cfg_t c;
    rst <= 1'b1;
    write_en <= 1'b0;
    reg_index <= REG_START_LOW;
    write_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.line_level <= 1'b0;
    seq_phase = PH_IDLE;
    dwell = '0;
    bits_got = 0;
    shift_reg = '0;
    answered = 1'b0;
    garble = 1'b0;
    data_bit = 1'b0;
    active_cfg = '{RST_START_LOW, RST_DRIVE_HIGH, RST_SETTLE, RST_RESP_CHECK,
                   RST_BIT_SAMPLE, RST_EDGE_TIMEOUT};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_cfg('{16'd2, 8'd1, 8'd1, 8'd1, 8'd1, 16'd3});
    for (i = 0; i < NUM_DIRECTED; i++)
      send_tick(dir_rows[i].kind, dir_rows[i].line, dir_rows[i].has_want, dir_rows[i].want);
    run_to_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      if (p == 0) c = '{16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0};
      else if (p == 1) c = '{16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1};
      else c = random_small_cfg();
      write_cfg(c);
      case (p % 4)
        0: begin tx_max = 17; rx_max = 17; end
        1: begin tx_max = 0; rx_max = 0; end
        2: begin tx_max = 17; rx_max = 0; end
        default: begin tx_max = 0; rx_max = 17; end
      endcase
      // receiver backs up while the sender keeps offering ticks
      if (p == 5) holds_asked++;
      run_random(ITEMS_PER_HALF);
      if (p == 6) wait_drain();
      run_random(ITEMS_PER_HALF);
      run_to_idle();
    end

    // widest settings, start pulse still low when the run ends
    wait_drain();
    write_cfg('{16'd65535, 8'd255, 8'd255, 8'd255, 8'd255, 16'd65535});
    tx_max = 0;
    rx_max = 0;
    garble = 1'b0;
    send_tick(KIND_START, 1'b1, 1'b0, ZERO_RESULT);
    send_tick(KIND_READ, 1'b1, 1'b0, ZERO_RESULT);
    for (i = 0; i < TAIL_TICKS; i++)
      send_tick(KIND_TICK, pick_line(), 1'b0, ZERO_RESULT);

    wait_drain();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbsr_pkg.sv
rtl/sbsr_in_if.sv
rtl/sbsr_out_if.sv
rtl/sbsr_cfg_regs.sv
rtl/sbsr_seq.sv
rtl/single_bus_sensor_byte_reader_unit.sv
tb/tb_single_bus_sensor_byte_reader_unit.sv
